// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the three-stack block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define TSA_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define TSA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tsa_pkg.sv
// Types and constants of the three-stack block.
`timescale 1ns / 1ps
package tsa_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W  = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

endpackage

// File: rtl/tsa_entry_ram.sv
// Single-port entry memory with registered read data.
`timescale 1ns / 1ps
module tsa_entry_ram #(
  parameter int unsigned DEPTH  = 192,
  parameter int unsigned ADDR_W = 8
) (
  input  logic                       clk_i,
  input  logic [ADDR_W-1:0]          addr_i,
  input  logic                       we_i,
  input  logic [tsa_pkg::WORD_W-1:0] wdata_i,
  input  logic                       re_i,
  output logic [tsa_pkg::WORD_W-1:0] rdata_o
);
  import tsa_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/three_stacks_in_one_array_top.sv
// Top level of the three-stack block: fill counters, control and result registers.
//
// Usage: several stacks share one word memory; stack k owns the slice that
// starts at k times the effective capacity. Raise start with an operation
// (push, pop, peek), a stack select and a push value; the transaction is
// taken at a rising edge where start is high and busy is low.
// Each transaction yields one result in the cycle after acceptance: result_valid_o is high
// for exactly that cycle with status, top value and empty/full flags. The
// receiver cannot stall, so the result is gone after that cycle.
// No new transaction is taken while a result is presented. On acceptance the
// fill counter is updated and the entry memory is written or read at the new
// top address; then the memory's registered read data is presented, with busy
// high. A successful push forwards its own value as the top.
// Configuration: capacity_per_stack is to be written over cfg_valid_i/cfg_ready_o
// only while idle; the block does not enforce this. cfg_ready_o is always high.
// Capacity 0 acts as 1, values above MAX_STACK_DEPTH act as MAX_STACK_DEPTH.
// Reset: fill counts clear to zero and capacity returns to 64; the entry
// memory is not cleared, no entry is readable before it has been pushed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module three_stacks_in_one_array_top #(
  parameter int unsigned MAX_STACK_DEPTH = 64,
  parameter int unsigned STACK_COUNT     = 3
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 operation_i,
  input  logic [1:0]                 stack_select_i,
  input  logic signed [31:0]         push_value_i,
  output logic                       result_valid_o,
  output logic [1:0]                 status_o,
  output logic signed [31:0]         top_value_o,
  output logic                       stack_empty_o,
  output logic                       stack_full_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tsa_pkg::CFG_W-1:0]  cfg_data_i
);
  import tsa_pkg::*;

  localparam int unsigned DEPTH  = STACK_COUNT * MAX_STACK_DEPTH;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_STACK_DEPTH + 1);
  localparam int unsigned CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Configuration register
  logic [CFG_W-1:0] capacity_q;
  logic [CNT_W-1:0] cap_eff;
  logic [CAP_W-1:0] cap_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Clamp the capacity into one to MAX_STACK_DEPTH
  always_comb begin
    cap_ext = CAP_W'(capacity_q);
    if (cap_ext == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_ext > CAP_W'(MAX_STACK_DEPTH)) begin
      cap_eff = CNT_W'(MAX_STACK_DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_ext);
    end
  end

  // Fill counters, one per stack
  logic [CNT_W-1:0] cnt_q [STACK_COUNT];
  logic [CNT_W-1:0] cnt_cur;
  logic [CNT_W-1:0] cnt_d;
  logic             sel_ok;
  logic             accept;
  status_e          status_d;
  logic             push_ok;

  assign accept = start && !busy;
  assign sel_ok = (int'(stack_select_i) < STACK_COUNT);

  // Select the addressed stack's count
  always_comb begin
    cnt_cur = '0;
    for (int i = 0; i < STACK_COUNT; i++) begin
      if (i == int'(stack_select_i)) begin
        cnt_cur = cnt_q[i];
      end
    end
  end

  // Decide the operation's effect on the count and the status
  always_comb begin
    cnt_d    = cnt_cur;
    status_d = ST_OK;
    push_ok  = 1'b0;
    unique case (op_e'(operation_i))
      OP_PUSH: begin
        if (cnt_cur >= cap_eff) begin
          status_d = ST_FULL;
        end else begin
          cnt_d   = cnt_cur + CNT_W'(1);
          push_ok = 1'b1;
        end
      end
      OP_POP: begin
        if (cnt_cur == '0) begin
          status_d = ST_EMPTY;
        end else begin
          cnt_d = cnt_cur - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        if (cnt_cur == '0) begin
          status_d = ST_EMPTY;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    if (!sel_ok) begin
      cnt_d    = '0;
      status_d = ST_EMPTY;
      push_ok  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (accept && sel_ok) begin
      for (int i = 0; i < STACK_COUNT; i++) begin
        if (i == int'(stack_select_i)) begin
          cnt_q[i] <= cnt_d;
        end
      end
    end
  end

  // Address of the new top: slice base plus count minus one
  logic [ADDR_W-1:0] slice_base;
  logic [ADDR_W-1:0] top_addr;

  assign slice_base = ADDR_W'(ADDR_W'(stack_select_i) * ADDR_W'(cap_eff));
  assign top_addr   = slice_base + ADDR_W'(cnt_d) - ADDR_W'(1);

  // Entry memory: write on a good push, otherwise read the new top if the stack is not left empty
  logic [WORD_W-1:0] ram_rdata;

  tsa_entry_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .addr_i  (top_addr),
    .we_i    (accept && push_ok),
    .wdata_i (push_value_i),
    .re_i    (accept && !push_ok && (cnt_d != '0)),
    .rdata_o (ram_rdata)
  );

  // Result registers
  logic              valid_q;
  status_e           status_q;
  logic              empty_q;
  logic              full_q;
  logic              fwd_q;
  logic [WORD_W-1:0] push_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      empty_q    <= (cnt_d == '0);
      full_q     <= sel_ok && (cnt_d >= cap_eff);
      fwd_q      <= push_ok;
      push_val_q <= push_value_i;
    end
  end

  assign busy           = valid_q;
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign stack_empty_o  = empty_q;
  assign stack_full_o   = full_q;
  assign top_value_o    = empty_q ? '0 :
                          fwd_q   ? $signed(push_val_q) : $signed(ram_rdata);

  // Checks
  `TSA_ASSERT(a_result_follows_accept, clk_i, rst_ni, accept |=> result_valid_o,
              "result strobe missing after an accepted transaction")
  `TSA_ASSERT(a_no_back_to_back, clk_i, rst_ni, result_valid_o |=> !result_valid_o,
              "two results in consecutive cycles")
  `TSA_ASSERT(a_flags_exclusive, clk_i, rst_ni,
              result_valid_o |-> !(stack_empty_o && stack_full_o),
              "stack reported both empty and full")
  `TSA_ASSERT(a_empty_top_zero, clk_i, rst_ni,
              (result_valid_o && stack_empty_o) |-> (top_value_o == '0),
              "empty stack reported a non-zero top")
  `TSA_ASSERT(a_full_status_flag, clk_i, rst_ni,
              (result_valid_o && (status_o == ST_FULL)) |-> stack_full_o,
              "full status without the full flag")
  `TSA_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !busy,
                     "busy asserted after a reset edge")

endmodule
